// ----- rtl/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Bridge frame deframer package
// Shared constants, state encoding and the command and status structures
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfd_pkg;

   localparam int PAYLOAD_MAX_DEFAULT = 64;
   localparam int HEADER_LEN          = 8;

   localparam logic [7:0] START_RESET = 8'hAA;
   localparam logic [7:0] END_RESET   = 8'h55;

   localparam int FLAG_EXT_BIT = 0;
   localparam int FLAG_FD_BIT  = 2;
   localparam int FLAG_BRS_BIT = 3;

   localparam logic CSR_START_VALUE = 1'b0;
   localparam logic CSR_END_VALUE   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_COLLECT = 4'b0010,
      ST_READ    = 4'b0100,
      ST_SHOW    = 4'b1000
   } state_type;

   typedef struct packed {
      logic capture_start;
      logic store_byte;
      logic read_issue;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic start_match;
      logic frame_end;
      logic end_ok;
      logic empty;
      logic last_result;
   } status_type;

endpackage

// ----- rtl/bfd_datapath.sv -----
// ----------------------------------------------------------------------------
// Bridge frame deframer datapath
// Configuration registers, fill position, header registers, payload memory
// and the result index counter.
// ----------------------------------------------------------------------------
module bfd_datapath #(
   parameter int PAYLOAD_MAX = bfd_pkg::PAYLOAD_MAX_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [7:0]         csr_data,
   input  logic [7:0]         rx_byte,
   input  bfd_pkg::cmd_type   cmd,
   output bfd_pkg::status_type status,
   output logic [31:0]        can_id,
   output logic               extended_id,
   output logic               fd_format,
   output logic               bit_rate_switch,
   output logic [3:0]         length_code,
   output logic [7:0]         length_raw,
   output logic [5:0]         byte_index,
   output logic [7:0]         payload_byte,
   output logic               has_data,
   output logic               last
);

   localparam int FRAME_LEN = bfd_pkg::HEADER_LEN + PAYLOAD_MAX + 1;
   localparam int POS_W     = $clog2(FRAME_LEN);
   localparam int IDX_W     = $clog2(PAYLOAD_MAX);
   localparam int CNT_W     = $clog2(PAYLOAD_MAX + 1);

   logic [7:0]       start_value_ff, start_value_in;
   logic [7:0]       end_value_ff, end_value_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [31:0]      id_ff;
   logic [7:0]       flags_ff;
   logic [7:0]       code_ff;
   logic [7:0]       len_ff;
   logic [7:0]       mem_q_ff;
   logic [7:0]       payload_mem [PAYLOAD_MAX];
   logic [CNT_W-1:0] count;
   logic             in_payload;
   logic [IDX_W-1:0] wr_addr;

   always_comb begin
      start_value_in = start_value_ff;
      end_value_in   = end_value_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bfd_pkg::CSR_START_VALUE: start_value_in = csr_data;
            bfd_pkg::CSR_END_VALUE:   end_value_in   = csr_data;
            default:                  start_value_in = start_value_ff;
         endcase
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.capture_start) begin
         pos_in = POS_W'(1);
      end else if (cmd.store_byte) begin
         pos_in = status.frame_end ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      index_in = index_ff;
      if (cmd.capture_start) begin
         index_in = '0;
      end else if (cmd.advance) begin
         index_in = index_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff <= bfd_pkg::START_RESET;
         end_value_ff   <= bfd_pkg::END_RESET;
         pos_ff         <= '0;
         index_ff       <= '0;
      end else begin
         start_value_ff <= start_value_in;
         end_value_ff   <= end_value_in;
         pos_ff         <= pos_in;
         index_ff       <= index_in;
      end
   end

   assign in_payload = !status.frame_end && (pos_ff >= POS_W'(bfd_pkg::HEADER_LEN));
   assign wr_addr    = IDX_W'(pos_ff - POS_W'(bfd_pkg::HEADER_LEN));

   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         unique case (pos_ff)
            POS_W'(1): id_ff[7:0]   <= rx_byte;
            POS_W'(2): id_ff[15:8]  <= rx_byte;
            POS_W'(3): id_ff[23:16] <= rx_byte;
            POS_W'(4): id_ff[31:24] <= rx_byte;
            POS_W'(5): flags_ff     <= rx_byte;
            POS_W'(6): code_ff      <= rx_byte;
            POS_W'(7): len_ff       <= rx_byte;
            default:   len_ff       <= len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store_byte && in_payload) begin
         payload_mem[wr_addr] <= rx_byte;
      end
      if (cmd.read_issue) begin
         mem_q_ff <= payload_mem[index_ff];
      end
   end

   assign count = (len_ff > 8'(PAYLOAD_MAX)) ? CNT_W'(PAYLOAD_MAX) : CNT_W'(len_ff);

   assign status.start_match = (rx_byte == start_value_ff);
   assign status.frame_end   = (pos_ff == POS_W'(FRAME_LEN - 1));
   assign status.end_ok      = (rx_byte == end_value_ff);
   assign status.empty       = (count == '0);
   assign status.last_result = status.empty || ((CNT_W'(index_ff) + CNT_W'(1)) == count);

   assign can_id          = id_ff;
   assign extended_id     = flags_ff[bfd_pkg::FLAG_EXT_BIT];
   assign fd_format       = flags_ff[bfd_pkg::FLAG_FD_BIT];
   assign bit_rate_switch = flags_ff[bfd_pkg::FLAG_BRS_BIT];
   assign length_code     = code_ff[3:0];
   assign length_raw      = len_ff;
   assign byte_index      = status.empty ? 6'd0 : 6'(index_ff);
   assign payload_byte    = status.empty ? 8'd0 : mem_q_ff;
   assign has_data        = !status.empty;
   assign last            = status.last_result;

endmodule

// ----- rtl/bfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bridge frame deframer controller
// Sequences frame collection, the end byte check and result emission.
// ----------------------------------------------------------------------------
module bfd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  bfd_pkg::status_type status,
   output bfd_pkg::cmd_type    cmd
);

   bfd_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in          = state_ff;
      cmd               = '0;
      req_stall         = 1'b1;
      rsp_valid         = 1'b0;
      unique case (state_ff)
         bfd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid && status.start_match) begin
               cmd.capture_start = 1'b1;
               state_in          = bfd_pkg::ST_COLLECT;
            end
         end
         bfd_pkg::ST_COLLECT: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.store_byte = 1'b1;
               if (status.frame_end) begin
                  priority if (!status.end_ok) begin
                     state_in = bfd_pkg::ST_IDLE;
                  end else if (status.empty) begin
                     state_in = bfd_pkg::ST_SHOW;
                  end else begin
                     state_in = bfd_pkg::ST_READ;
                  end
               end
            end
         end
         bfd_pkg::ST_READ: begin
            cmd.read_issue = 1'b1;
            state_in       = bfd_pkg::ST_SHOW;
         end
         bfd_pkg::ST_SHOW: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.last_result) begin
                  state_in = bfd_pkg::ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = bfd_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = bfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/bridge_frame_deframer.sv -----
// A byte is taken in the cycle it is presented. The end byte of a good frame
// leads to the read state, which issues the registered payload memory read,
// then to the show state; for an empty payload the result shows in the cycle
// after its end byte. Throughput: one byte per cycle while collecting.
// Reset is synchronous and active high; it leaves the block idle, hunting for
// the start byte, with both configuration registers at their reset values.
// ----------------------------------------------------------------------------
// Bridge frame deframer
// Collects fixed-size frames from a serial byte stream and emits one result
// transaction per payload byte of each frame whose end byte checks good, or one empty result when its length is zero.
// ----------------------------------------------------------------------------
module bridge_frame_deframer #(
   parameter int PAYLOAD_MAX = bfd_pkg::PAYLOAD_MAX_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_can_id,
   output logic        rsp_extended_id,
   output logic        rsp_fd_format,
   output logic        rsp_bit_rate_switch,
   output logic [3:0]  rsp_length_code,
   output logic [7:0]  rsp_length_raw,
   output logic [5:0]  rsp_byte_index,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_has_data,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);

   bfd_pkg::cmd_type    cmd;
   bfd_pkg::status_type status;

   assign csr_ready = 1'b1;

   bfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bfd_datapath #(
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rx_byte         (req_rx_byte),
      .cmd             (cmd),
      .status          (status),
      .can_id          (rsp_can_id),
      .extended_id     (rsp_extended_id),
      .fd_format       (rsp_fd_format),
      .bit_rate_switch (rsp_bit_rate_switch),
      .length_code     (rsp_length_code),
      .length_raw      (rsp_length_raw),
      .byte_index      (rsp_byte_index),
      .payload_byte    (rsp_payload_byte),
      .has_data        (rsp_has_data),
      .last            (rsp_last)
   );

endmodule

// ----- rtl/bfd_port_checker.sv -----
// ----------------------------------------------------------------------------
// Bridge frame deframer port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module bfd_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_can_id,
   input logic [5:0]  rsp_byte_index,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_has_data,
   input logic        rsp_last
);

   a_no_input_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while a result transaction is pending");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_can_id)
         && $stable(rsp_byte_index) && $stable(rsp_payload_byte)))
      else $error("stalled result transaction changed");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |-> ##2
         (rsp_valid && rsp_byte_index == $past(rsp_byte_index, 2) + 6'd1
          && rsp_can_id == $past(rsp_can_id, 2)))
      else $error("next result of the frame has wrong index or identifier");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_data) |-> (rsp_last && rsp_byte_index == 6'd0
         && rsp_payload_byte == 8'd0))
      else $error("empty payload result is malformed");

endmodule

bind bridge_frame_deframer bfd_port_checker u_bfd_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_can_id       (rsp_can_id),
   .rsp_byte_index   (rsp_byte_index),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_has_data     (rsp_has_data),
   .rsp_last         (rsp_last)
);
